// ===== rtl/mjdjd_pkg.sv =====
// Constants and month tables for the MJD to Julian calendar date converter.
package mjdjd_pkg;

	localparam int unsigned MJD_W     = 32;
	localparam int unsigned YEAR_W    = 24;
	localparam int unsigned MONTH_W   = 4;
	localparam int unsigned DOM_W     = 5;
	localparam int unsigned DOY_W     = 9;

	// Day number is rebased to 1860-03-01 and lifted by a whole number of cycles
	// so that the floor division works on a non-negative value.
	localparam int unsigned CYCLE_DAYS  = 1461;
	localparam int unsigned YEAR_DAYS   = 365;
	localparam int unsigned MAR_TO_DEC  = 306;
	localparam int unsigned BASE_YEAR   = 1860;
	localparam int unsigned MJD_BASE    = 482;
	localparam int unsigned CYCLE_BIAS  = 1470000;
	localparam longint unsigned LIFT    =
		longint'(CYCLE_BIAS) * longint'(CYCLE_DAYS) - longint'(MJD_BASE);

	localparam int unsigned U_W    = 33;   // lifted day number
	localparam int unsigned A_W    = 22;   // top bits fed to the reciprocal multiply
	localparam int unsigned RSH    = 11;   // bits dropped before the multiply
	localparam int unsigned RECIP_SH = 24;
	localparam int unsigned RECIP_W  = 25;
	localparam logic [RECIP_W-1:0] RECIP = 25'd23517959; // floor(2^35 / 1461)
	localparam int unsigned Q_W    = 22;   // cycle quotient
	localparam int unsigned R0_W   = 13;   // remainder before correction, below 4 periods of 1461 days
	localparam int unsigned OFF_W  = 11;   // offset within a 1461-day period
	localparam int unsigned CYC_W  = 23;   // signed cycle count
	localparam int unsigned DAY_W  = 9;    // March-based day of year

	localparam int unsigned JANFEB_COMMON = 31 + 28;
	localparam int unsigned JANFEB_LEAP   = 31 + 29;

	typedef logic [3:0] mon_idx_t;

	function automatic logic [DAY_W-1:0] month_start(input mon_idx_t idx);
		logic [DAY_W-1:0] s;
		unique case (idx)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	function automatic logic [MONTH_W-1:0] month_code(input mon_idx_t idx);
		logic [MONTH_W-1:0] c;
		unique case (idx)
			4'd0:    c = 4'd3;
			4'd1:    c = 4'd4;
			4'd2:    c = 4'd5;
			4'd3:    c = 4'd6;
			4'd4:    c = 4'd7;
			4'd5:    c = 4'd8;
			4'd6:    c = 4'd9;
			4'd7:    c = 4'd10;
			4'd8:    c = 4'd11;
			4'd9:    c = 4'd12;
			4'd10:   c = 4'd1;
			4'd11:   c = 4'd2;
			default: c = 4'd1;
		endcase
		return c;
	endfunction

	// Last March-based month whose first day is not after the given day.
	function automatic mon_idx_t month_index(input logic [DAY_W-1:0] day);
		mon_idx_t m;
		m = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (month_start(mon_idx_t'(i)) <= day) m = mon_idx_t'(i);
		end
		return m;
	endfunction

endpackage

// ===== rtl/mjd_to_julian_date_core.sv =====
// Modified Julian Day to proleptic Julian calendar date converter, top level.
//
// Converts one signed 32-bit Modified Julian Day word into a Julian calendar
// date (astronomical year, month 1-12, day of month 1-31, zero-based day of
// year 0-365). Every input word gives exactly one result word. The block is a
// five-stage pipeline and takes one word per clock, back to back, while the
// output accepts words. A word passes through the stages in order and is
// presented from the last stage's result register. The depth is set by the
// floor division by the 1461-day cycle. The 22 x 25 bit reciprocal multiply
// has a stage to itself. It is followed by a stage that forms the remainder
// and a stage that corrects the quotient by up to three 1461-day periods.
// Each stage holds its word until the next one is free, so bubbles close up.
// The input is refused only when all five stages are full and the output is
// held off. Negative day numbers use floor division, so dates before 1860
// come out right for the whole 32-bit input range. No state is kept between
// words and reset only empties the pipeline.
module mjd_to_julian_date_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [mjdjd_pkg::MJD_W-1:0] mjd,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [mjdjd_pkg::YEAR_W-1:0] calendar_year,
	output logic [mjdjd_pkg::MONTH_W-1:0]      month_number,
	output logic [mjdjd_pkg::DOM_W-1:0]        day_of_month,
	output logic [mjdjd_pkg::DOY_W-1:0]        day_of_year
);

	localparam int unsigned P_W = mjdjd_pkg::A_W + mjdjd_pkg::RECIP_W;

	// Stage valid flags and per-stage advance
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	// A stage may load when it is empty or its word moves on this cycle.
	assign rdy_s5 = !v_s5 || out_ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: rebase to 1860-03-01 and lift by a whole number of cycles so
	// the value is never negative; the quotient bias is taken off later.
	// ---------------------------------------------------------------------
	logic [mjdjd_pkg::U_W-1:0] u_s1;
	logic [mjdjd_pkg::U_W:0]   u_sum;

	assign u_sum = {{(mjdjd_pkg::U_W + 1 - mjdjd_pkg::MJD_W){mjd[mjdjd_pkg::MJD_W-1]}}, mjd}
		+ (mjdjd_pkg::U_W + 1)'(mjdjd_pkg::LIFT);

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) u_s1 <= u_sum[mjdjd_pkg::U_W-1:0];
	end

	// ---------------------------------------------------------------------
	// Stage 2: reciprocal multiply on the upper bits gives a quotient that is
	// low by at most three 1461-day periods.
	// ---------------------------------------------------------------------
	logic [mjdjd_pkg::U_W-1:0] u_s2;
	logic [P_W-1:0]            prod_s2;
	logic [mjdjd_pkg::A_W-1:0] a_hi;

	assign a_hi = u_s1[mjdjd_pkg::U_W-1:mjdjd_pkg::RSH];

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			u_s2    <= u_s1;
			prod_s2 <= P_W'(a_hi) * P_W'(mjdjd_pkg::RECIP);
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: remainder against the estimated quotient.
	// ---------------------------------------------------------------------
	logic [mjdjd_pkg::Q_W-1:0]  q0;
	logic [mjdjd_pkg::U_W-1:0]  r0_full;
	logic [mjdjd_pkg::Q_W-1:0]  q0_s3;
	logic [mjdjd_pkg::R0_W-1:0] r0_s3;

	assign q0      = prod_s2[mjdjd_pkg::RECIP_SH +: mjdjd_pkg::Q_W];
	assign r0_full = u_s2 - mjdjd_pkg::U_W'(q0) * mjdjd_pkg::U_W'(mjdjd_pkg::CYCLE_DAYS);

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			q0_s3 <= q0;
			r0_s3 <= r0_full[mjdjd_pkg::R0_W-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: correct the quotient, drop the bias, split the cycle into
	// March-based years. The last day of a cycle is Feb 29 of year three.
	// ---------------------------------------------------------------------
	localparam logic [mjdjd_pkg::R0_W-1:0] C1 = mjdjd_pkg::R0_W'(mjdjd_pkg::CYCLE_DAYS);
	localparam logic [mjdjd_pkg::R0_W-1:0] C2 = mjdjd_pkg::R0_W'(2 * mjdjd_pkg::CYCLE_DAYS);
	localparam logic [mjdjd_pkg::R0_W-1:0] C3 = mjdjd_pkg::R0_W'(3 * mjdjd_pkg::CYCLE_DAYS);
	localparam logic [mjdjd_pkg::OFF_W-1:0] Y1 = mjdjd_pkg::OFF_W'(mjdjd_pkg::YEAR_DAYS);
	localparam logic [mjdjd_pkg::OFF_W-1:0] Y2 = mjdjd_pkg::OFF_W'(2 * mjdjd_pkg::YEAR_DAYS);
	localparam logic [mjdjd_pkg::OFF_W-1:0] Y3 = mjdjd_pkg::OFF_W'(3 * mjdjd_pkg::YEAR_DAYS);
	localparam logic [mjdjd_pkg::OFF_W-1:0] LEAP_OFF =
		mjdjd_pkg::OFF_W'(mjdjd_pkg::CYCLE_DAYS - 1);

	logic [mjdjd_pkg::R0_W-1:0]  r_fix;
	logic [1:0]                  q_adj;
	logic [mjdjd_pkg::OFF_W-1:0] off;
	logic [mjdjd_pkg::Q_W-1:0]   q_fix;
	logic signed [mjdjd_pkg::CYC_W-1:0] cyc;
	logic [1:0]                  yr;
	logic [mjdjd_pkg::OFF_W-1:0] day_wide;

	always_comb begin
		priority if (r0_s3 >= C3) begin
			q_adj = 2'd3;
			r_fix = r0_s3 - C3;
		end else if (r0_s3 >= C2) begin
			q_adj = 2'd2;
			r_fix = r0_s3 - C2;
		end else if (r0_s3 >= C1) begin
			q_adj = 2'd1;
			r_fix = r0_s3 - C1;
		end else begin
			q_adj = 2'd0;
			r_fix = r0_s3;
		end
		off   = r_fix[mjdjd_pkg::OFF_W-1:0];
		q_fix = q0_s3 + mjdjd_pkg::Q_W'(q_adj);
		cyc   = $signed({1'b0, q_fix}) - mjdjd_pkg::CYC_W'(mjdjd_pkg::CYCLE_BIAS);

		priority if (off == LEAP_OFF) begin
			yr       = 2'd3;
			day_wide = Y1;
		end else if (off >= Y3) begin
			yr       = 2'd3;
			day_wide = off - Y3;
		end else if (off >= Y2) begin
			yr       = 2'd2;
			day_wide = off - Y2;
		end else if (off >= Y1) begin
			yr       = 2'd1;
			day_wide = off - Y1;
		end else begin
			yr       = 2'd0;
			day_wide = off;
		end
	end

	logic signed [mjdjd_pkg::CYC_W-1:0] cyc_s4;
	logic [1:0]                         yr_s4;
	logic [mjdjd_pkg::DAY_W-1:0]        day_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			cyc_s4 <= cyc;
			yr_s4  <= yr;
			day_s4 <= day_wide[mjdjd_pkg::DAY_W-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Stage 5: month lookup, January/February roll into the next year, and
	// day of year counted from January 1. Result register.
	// ---------------------------------------------------------------------
	localparam logic [mjdjd_pkg::DAY_W-1:0] MD =
		mjdjd_pkg::DAY_W'(mjdjd_pkg::MAR_TO_DEC);

	mjdjd_pkg::mon_idx_t               m_idx;
	logic [mjdjd_pkg::DAY_W-1:0]       m_start;
	logic [mjdjd_pkg::DAY_W-1:0]       dom_wide;
	logic [mjdjd_pkg::DAY_W-1:0]       doy;
	logic [2:0]                        yr_full;
	logic signed [mjdjd_pkg::YEAR_W-1:0] year;

	always_comb begin
		m_idx    = mjdjd_pkg::month_index(day_s4);
		m_start  = mjdjd_pkg::month_start(m_idx);
		dom_wide = day_s4 - m_start + mjdjd_pkg::DAY_W'(1);
		priority if (day_s4 >= MD) begin
			yr_full = {1'b0, yr_s4} + 3'd1;
			doy     = day_s4 - MD;
		end else if (yr_s4 != 2'd0) begin
			yr_full = {1'b0, yr_s4};
			doy     = day_s4 + mjdjd_pkg::DAY_W'(mjdjd_pkg::JANFEB_COMMON);
		end else begin
			yr_full = {1'b0, yr_s4};
			doy     = day_s4 + mjdjd_pkg::DAY_W'(mjdjd_pkg::JANFEB_LEAP);
		end
		year = (mjdjd_pkg::YEAR_W'(cyc_s4) <<< 2)
			+ mjdjd_pkg::YEAR_W'(mjdjd_pkg::BASE_YEAR)
			+ mjdjd_pkg::YEAR_W'(yr_full);
	end

	logic signed [mjdjd_pkg::YEAR_W-1:0] year_s5;
	logic [mjdjd_pkg::MONTH_W-1:0]       mon_s5;
	logic [mjdjd_pkg::DOM_W-1:0]         dom_s5;
	logic [mjdjd_pkg::DOY_W-1:0]         doy_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			year_s5 <= year;
			mon_s5  <= mjdjd_pkg::month_code(m_idx);
			dom_s5  <= dom_wide[mjdjd_pkg::DOM_W-1:0];
			doy_s5  <= doy;
		end
	end

	assign calendar_year = year_s5;
	assign month_number  = mon_s5;
	assign day_of_month  = dom_s5;
	assign day_of_year   = doy_s5;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	// The reciprocal estimate must leave the remainder below four 1461-day periods.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (r0_s3 < mjdjd_pkg::R0_W'(4 * mjdjd_pkg::CYCLE_DAYS)))
		else $error("quotient estimate out of correction range");

	// March-based day never passes the leap day.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (day_s4 <= mjdjd_pkg::DAY_W'(mjdjd_pkg::YEAR_DAYS)))
		else $error("day within year out of range");

	// Presented result is a real date.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month_number >= 4'd1 && month_number <= 4'd12
			&& day_of_month != 5'd0 && day_of_year <= 9'd365))
		else $error("result date fields out of range");

	// An empty first stage must never refuse a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input refused with first stage empty");

endmodule
